@@ hdl/ready_queue_scheduler_core_assert.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// Plain invariant, checked every clock outside reset.
`define RQS_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication, checked every clock outside reset.
`define RQS_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/rqs_pkg.sv @@
`timescale 1ns / 1ps
package rqs_pkg;
  localparam int QUEUE_DEPTH = 8;
  localparam int ADDR_BITS   = 10;
  localparam int LINE_W      = ADDR_BITS + 1;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PID_W       = 8;
  localparam int SCORE_W     = ADDR_BITS;
  localparam int CFG_W       = 4;
  localparam int IN_TDATA_W  = ((2 * ADDR_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = PID_W + LINE_W + 1 + 2 * ADDR_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SJF   = 2'd1,
    POL_RR    = 2'd2,
    POL_AGING = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_ISSUED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ADDED  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_QUANTUM = 2'd1;
  localparam logic [1:0] CFG_SLICE   = 2'd2;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic [PID_W-1:0]     pid;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] length;
    logic [SCORE_W-1:0]   score;
    logic [LINE_W-1:0]    pc;
  } rqs_entry_t;
endpackage

@@ hdl/ready_queue_scheduler_core.sv @@
`timescale 1ns / 1ps
// Ready-queue scheduler, one word in flight at a time, entries in one RAM (registered read).
// Add: an optional SJF/AGING scan for the insert position, a shift of entries toward the
//   tail, then the write. Step: an update of the selected entry, plus removal, an aging
//   pass or a promotion where they apply; all entry reads go through the single RAM read
//   port. A new word is accepted only once the previous result is registered for output.
// Reset (sync, rst_n low): queue empty, pid 0, cursor/slice/stop flag 0, policy FCFS,
//   quantum 2, aging slice 1. RAM contents are not cleared; slots past the count are unused.
module ready_queue_scheduler_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rqs_pkg::IN_TDATA_W-1:0]  in_tdata,   // start_addr, prog_length
  input  logic [0:0]                     in_tuser,   // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rqs_pkg::OUT_TDATA_W-1:0] out_tdata,  // proc_id, line_addr, finished,
                                                     // release_start, release_length
  output logic [1:0]                     out_tuser,  // status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [rqs_pkg::CFG_W-1:0]      cfg_data
);
  import rqs_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_SCAN_RD   = 19'h00002,
    S_SCAN_CHK  = 19'h00004,
    S_SHD_RD    = 19'h00008,
    S_SHD_WR    = 19'h00010,
    S_ADD_WR    = 19'h00020,
    S_STEP_WR   = 19'h00040,
    S_AGE_RD    = 19'h00080,
    S_AGE_WR    = 19'h00100,
    S_AGE_END   = 19'h00200,
    S_SHU_RD    = 19'h00400,
    S_SHU_WR    = 19'h00800,
    S_PRO_H     = 19'h01000,
    S_PRO_L     = 19'h02000,
    S_PRO_LCAP  = 19'h04000,
    S_PRO_SH_RD = 19'h08000,
    S_PRO_SH_WR = 19'h10000,
    S_PRO_W0    = 19'h20000,
    S_DONE      = 19'h40000
  } state_t;

  // entry RAM
  rqs_entry_t mem [QUEUE_DEPTH];
  rqs_entry_t rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  rqs_entry_t       mem_wdata;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PID_W-1:0]     next_pid_r, next_pid_nxt;
  logic [IDX_W-1:0]     cursor_r, cursor_nxt;
  logic [3:0]           slice_r, slice_nxt;
  logic                 stopped_r, stopped_nxt;
  policy_t              policy_r, policy_nxt;
  logic [3:0]           quantum_r, quantum_nxt;
  logic [3:0]           aslice_r, aslice_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [ADDR_BITS-1:0] len_r, len_nxt;
  logic [ADDR_BITS-1:0] st_r, st_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 done_r, done_nxt;
  logic                 allz_r, allz_nxt;
  logic                 prom_r, prom_nxt;
  logic [SCORE_W-1:0]   min_score_r, min_score_nxt;
  logic [IDX_W-1:0]     min_pos_r, min_pos_nxt;
  logic                 min_valid_r, min_valid_nxt;
  rqs_entry_t           h_r, h_nxt, l_r, l_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [PID_W-1:0]     res_pid_r, res_pid_nxt;
  logic [LINE_W-1:0]    res_line_r, res_line_nxt;
  logic                 res_fin_r, res_fin_nxt;
  logic [ADDR_BITS-1:0] res_rs_r, res_rs_nxt, res_rl_r, res_rl_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  status_t              out_status_r, out_status_nxt;

  // scratch values
  logic [CNT_W-1:0]   kp1, km1, cnt_dec, idx_inc;
  logic [IDX_W-1:0]   step_idx;
  logic [LINE_W-1:0]  line_v;
  logic               done_v;
  logic [3:0]         slice_inc;
  logic [SCORE_W-1:0] s_dec;
  logic [CNT_W-1:0]   new_pos;
  rqs_entry_t         e_upd;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign cfg_ready  = 1'b1;

  assign kp1       = k_r + 1'b1;
  assign km1       = k_r - 1'b1;
  assign cnt_dec   = count_r - 1'b1;
  assign idx_inc   = CNT_W'(idx_r) + 1'b1;
  assign slice_inc = slice_r + 1'b1;
  assign step_idx  = (policy_r == POL_RR && CNT_W'(cursor_r) < count_r) ? cursor_r : '0;
  assign line_v    = LINE_W'(rdata_r.start) + rdata_r.pc - 1'b1;
  assign done_v    = rdata_r.pc >= LINE_W'(rdata_r.length);
  assign s_dec     = (rdata_r.score != '0) ? rdata_r.score - 1'b1 : rdata_r.score;
  assign new_pos   = done_r ? km1 : k_r;

  always_comb begin
    e_upd = rdata_r;
    e_upd.pc = rdata_r.pc + 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    next_pid_nxt   = next_pid_r;
    cursor_nxt     = cursor_r;
    slice_nxt      = slice_r;
    stopped_nxt    = stopped_r;
    policy_nxt     = policy_r;
    quantum_nxt    = quantum_r;
    aslice_nxt     = aslice_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    st_nxt         = st_r;
    idx_nxt        = idx_r;
    done_nxt       = done_r;
    allz_nxt       = allz_r;
    prom_nxt       = prom_r;
    min_score_nxt  = min_score_r;
    min_pos_nxt    = min_pos_r;
    min_valid_nxt  = min_valid_r;
    h_nxt          = h_r;
    l_nxt          = l_r;
    res_status_nxt = res_status_r;
    res_pid_nxt    = res_pid_r;
    res_line_nxt   = res_line_r;
    res_fin_nxt    = res_fin_r;
    res_rs_nxt     = res_rs_r;
    res_rl_nxt     = res_rl_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = rdata_r;
    mem_raddr      = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_POLICY:  policy_nxt  = policy_t'(cfg_data[1:0]);
        CFG_QUANTUM: quantum_nxt = cfg_data;
        CFG_SLICE:   aslice_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        mem_raddr = step_idx;
        if (in_tvalid) begin
          res_pid_nxt  = '0;
          res_line_nxt = '0;
          res_fin_nxt  = 1'b0;
          res_rs_nxt   = '0;
          res_rl_nxt   = '0;
          prom_nxt     = 1'b0;
          st_nxt       = in_tdata[ADDR_BITS-1:0];
          len_nxt      = in_tdata[2*ADDR_BITS-1:ADDR_BITS];
          if (in_tuser[0] == KIND_ADD) begin
            pos_nxt = count_r;
            k_nxt   = count_r;
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else if ((policy_r inside {POL_SJF, POL_AGING}) && count_r != '0) begin
              k_nxt     = '0;
              state_nxt = S_SCAN_RD;
            end else begin
              state_nxt = S_SHD_RD;
            end
          end else if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt = step_idx;
            if (policy_r == POL_RR) cursor_nxt = step_idx;
            state_nxt = S_STEP_WR;
          end
        end
      end

      // find first strictly longer entry
      S_SCAN_RD: begin
        mem_raddr = k_r[IDX_W-1:0];
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata_r.length > len_r) begin
          pos_nxt   = k_r;
          k_nxt     = count_r;
          state_nxt = S_SHD_RD;
        end else if (kp1 == count_r) begin
          k_nxt     = count_r;
          state_nxt = S_SHD_RD;
        end else begin
          k_nxt     = kp1;
          state_nxt = S_SCAN_RD;
        end
      end

      // open a hole at pos, moving entries toward the tail
      S_SHD_RD: begin
        mem_raddr = km1[IDX_W-1:0];
        state_nxt = (k_r == pos_r) ? S_ADD_WR : S_SHD_WR;
      end
      S_SHD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        mem_wdata = rdata_r;
        k_nxt     = km1;
        state_nxt = S_SHD_RD;
      end
      S_ADD_WR: begin
        mem_we           = 1'b1;
        mem_waddr        = pos_r[IDX_W-1:0];
        mem_wdata.pid    = next_pid_r;
        mem_wdata.start  = st_r;
        mem_wdata.length = len_r;
        mem_wdata.score  = len_r;
        mem_wdata.pc     = LINE_W'(1);
        count_nxt        = count_r + 1'b1;
        next_pid_nxt     = next_pid_r + 1'b1;
        res_status_nxt   = ST_ADDED;
        res_pid_nxt      = next_pid_r;
        state_nxt        = S_DONE;
      end

      S_STEP_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = idx_r;
        mem_wdata      = e_upd;
        done_nxt       = done_v;
        res_status_nxt = ST_ISSUED;
        res_pid_nxt    = rdata_r.pid;
        res_line_nxt   = line_v;
        res_fin_nxt    = done_v;
        if (done_v) begin
          res_rs_nxt = rdata_r.start;
          res_rl_nxt = rdata_r.length;
        end
        state_nxt = S_DONE;
        case (policy_r)
          POL_FCFS, POL_SJF: begin
            if (done_v) begin
              k_nxt     = '0;
              state_nxt = S_SHU_RD;
            end
          end
          POL_RR: begin
            slice_nxt = slice_inc;
            if (done_v) begin
              slice_nxt = '0;
              k_nxt     = CNT_W'(idx_r);
              state_nxt = S_SHU_RD;
            end else if (slice_inc >= quantum_r) begin
              slice_nxt  = '0;
              cursor_nxt = (idx_inc >= count_r) ? '0 : idx_inc[IDX_W-1:0];
            end
          end
          default: begin
            slice_nxt = slice_inc;
            if (done_v || slice_inc >= aslice_r) begin
              slice_nxt = '0;
              if (!stopped_r) begin
                // head keeps its score; it is a promotion candidate unless leaving
                allz_nxt      = (rdata_r.score == '0);
                min_score_nxt = rdata_r.score;
                min_pos_nxt   = '0;
                min_valid_nxt = !done_v;
                k_nxt         = CNT_W'(1);
                state_nxt     = (count_r > CNT_W'(1)) ? S_AGE_RD : S_AGE_END;
              end else if (done_v) begin
                k_nxt     = '0;
                state_nxt = S_SHU_RD;
              end
            end
          end
        endcase
      end

      // decrement scores of non-head entries, track first lowest
      S_AGE_RD: begin
        mem_raddr = k_r[IDX_W-1:0];
        state_nxt = S_AGE_WR;
      end
      S_AGE_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = k_r[IDX_W-1:0];
        mem_wdata       = rdata_r;
        mem_wdata.score = s_dec;
        if (rdata_r.score != '0) allz_nxt = 1'b0;
        if (!min_valid_r || s_dec < min_score_r) begin
          min_score_nxt = s_dec;
          min_pos_nxt   = new_pos[IDX_W-1:0];
          min_valid_nxt = 1'b1;
        end
        k_nxt     = kp1;
        state_nxt = (kp1 == count_r) ? S_AGE_END : S_AGE_RD;
      end
      S_AGE_END: begin
        stopped_nxt = allz_r;
        if (done_r) begin
          prom_nxt  = 1'b1;
          k_nxt     = '0;
          state_nxt = S_SHU_RD;
        end else begin
          state_nxt = (min_pos_r == '0) ? S_DONE : S_PRO_H;
        end
      end

      // remove entry k, closing the gap toward the head
      S_SHU_RD: begin
        mem_raddr = kp1[IDX_W-1:0];
        if (kp1 >= count_r) begin
          count_nxt = cnt_dec;
          if (CNT_W'(cursor_r) >= cnt_dec) cursor_nxt = '0;
          if (cnt_dec == '0) begin
            slice_nxt   = '0;
            stopped_nxt = 1'b0;
          end
          if (prom_r && cnt_dec != '0 && min_pos_r != '0) state_nxt = S_PRO_H;
          else state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHU_WR;
        end
      end
      S_SHU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        mem_wdata = rdata_r;
        k_nxt     = kp1;
        state_nxt = S_SHU_RD;
      end

      // promotion: lowest to head, old head to tail
      S_PRO_H: begin
        mem_raddr = '0;
        state_nxt = S_PRO_L;
      end
      S_PRO_L: begin
        h_nxt     = rdata_r;
        mem_raddr = min_pos_r;
        state_nxt = S_PRO_LCAP;
      end
      S_PRO_LCAP: begin
        l_nxt     = rdata_r;
        k_nxt     = CNT_W'(min_pos_r);
        state_nxt = S_PRO_SH_RD;
      end
      S_PRO_SH_RD: begin
        mem_raddr = kp1[IDX_W-1:0];
        if (k_r == cnt_dec) begin
          mem_we    = 1'b1;
          mem_waddr = k_r[IDX_W-1:0];
          mem_wdata = h_r;
          state_nxt = S_PRO_W0;
        end else begin
          state_nxt = S_PRO_SH_WR;
        end
      end
      S_PRO_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        mem_wdata = rdata_r;
        k_nxt     = kp1;
        state_nxt = S_PRO_SH_RD;
      end
      S_PRO_W0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = l_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = OUT_TDATA_W'({res_rl_r, res_rs_r, res_fin_r, res_line_r, res_pid_r});
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_pid_r  <= '0;
      cursor_r    <= '0;
      slice_r     <= '0;
      stopped_r   <= 1'b0;
      policy_r    <= POL_FCFS;
      quantum_r   <= 4'd2;
      aslice_r    <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_pid_r  <= next_pid_nxt;
      cursor_r    <= cursor_nxt;
      slice_r     <= slice_nxt;
      stopped_r   <= stopped_nxt;
      policy_r    <= policy_nxt;
      quantum_r   <= quantum_nxt;
      aslice_r    <= aslice_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    pos_r        <= pos_nxt;
    len_r        <= len_nxt;
    st_r         <= st_nxt;
    idx_r        <= idx_nxt;
    done_r       <= done_nxt;
    allz_r       <= allz_nxt;
    prom_r       <= prom_nxt;
    min_score_r  <= min_score_nxt;
    min_pos_r    <= min_pos_nxt;
    min_valid_r  <= min_valid_nxt;
    h_r          <= h_nxt;
    l_r          <= l_nxt;
    res_status_r <= res_status_nxt;
    res_pid_r    <= res_pid_nxt;
    res_line_r   <= res_line_nxt;
    res_fin_r    <= res_fin_nxt;
    res_rs_r     <= res_rs_nxt;
    res_rl_r     <= res_rl_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  `include "ready_queue_scheduler_core_assert.svh"

  `RQS_CHECK(a_count_range, count_r <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `RQS_CHECK_IMP(a_idle_no_write, state_r == S_IDLE, !mem_we, "RAM written while idle")
  `RQS_CHECK_IMP(a_stop_nonempty, stopped_r, count_r != '0, "aging stop set on empty queue")
  `RQS_CHECK_IMP(a_count_step, count_r != $past(count_r),
                 (count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1),
                 "queue count jumped")
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Scheduler testbench: a queue of pending words feeds a clocked driver; a clocked
// monitor checks every result word against a local model of the ready queue.
module tb_top;
  import rqs_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // start_addr, prog_length
  logic [0:0]             in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // proc_id, line_addr, finished,
                                      // release_start, release_length
  logic [1:0]             out_tuser;  // status
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  ready_queue_scheduler_core uut (.*);

  typedef struct {
    logic                 kind;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } sched_word_t;

  typedef struct {
    status_t              status;
    logic [PID_W-1:0]     pid;
    logic [LINE_W-1:0]    line;
    logic                 fin;
    logic [ADDR_BITS-1:0] rel_start;
    logic [ADDR_BITS-1:0] rel_len;
  } sched_result_t;

  sched_word_t   pending_words[$];
  sched_result_t expected_results[$];

  // Local copy of the ready queue; slot 0 is the head.
  logic [PID_W-1:0]     rq_pid   [QUEUE_DEPTH];
  logic [ADDR_BITS-1:0] rq_start [QUEUE_DEPTH];
  logic [ADDR_BITS-1:0] rq_len   [QUEUE_DEPTH];
  logic [SCORE_W-1:0]   rq_score [QUEUE_DEPTH];
  logic [LINE_W-1:0]    rq_pc    [QUEUE_DEPTH];
  int                   rq_count;
  logic [PID_W-1:0]     pid_ctr;
  int                   rr_pos;
  logic [3:0]           slice_ctr;
  logic                 aging_frozen;
  policy_t              cur_policy;
  logic [3:0]           cur_quantum;
  logic [3:0]           cur_slice;

  int  errors;
  bit  idle_on;
  int  step_pct;
  bit  long_hold_go;
  bit  long_hold_done;
  int  hold_left;
  int  send_gap;
  int  recv_gap;
  int  quiet_cycles;
  sched_word_t cur_word;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic void copy_slot(int dst, int src);
    rq_pid[dst]   = rq_pid[src];
    rq_start[dst] = rq_start[src];
    rq_len[dst]   = rq_len[src];
    rq_score[dst] = rq_score[src];
    rq_pc[dst]    = rq_pc[src];
  endfunction

  function automatic void remove_slot(int pos);
    for (int k = pos; k + 1 < rq_count; k++) copy_slot(k, k + 1);
    rq_count--;
    if (rr_pos >= rq_count) rr_pos = 0;
    if (rq_count == 0) begin
      slice_ctr    = '0;
      aging_frozen = 1'b0;
    end
  endfunction

  // Lower every nonzero non-head score; true when all scores, the head's too, were zero.
  function automatic bit age_queue();
    bit all_zero;
    all_zero = (rq_score[0] == 0);
    for (int k = 1; k < rq_count; k++)
      if (rq_score[k] > 0) begin
        all_zero = 0;
        rq_score[k]--;
      end
    return all_zero;
  endfunction

  // First lowest score moves to the head, the old head to the tail.
  function automatic void promote_lowest_score();
    int low;
    int last;
    logic [PID_W-1:0]     hp;
    logic [ADDR_BITS-1:0] hs, hl;
    logic [SCORE_W-1:0]   hsc;
    logic [LINE_W-1:0]    hpc;
    low = 0;
    for (int k = 1; k < rq_count; k++)
      if (rq_score[k] < rq_score[low]) low = k;
    if (low == 0) return;
    last = rq_count - 1;
    hp = rq_pid[0]; hs = rq_start[0]; hl = rq_len[0]; hsc = rq_score[0]; hpc = rq_pc[0];
    copy_slot(0, low);
    for (int k = low; k < last; k++) copy_slot(k, k + 1);
    rq_pid[last] = hp; rq_start[last] = hs; rq_len[last] = hl;
    rq_score[last] = hsc; rq_pc[last] = hpc;
  endfunction

  function automatic sched_result_t schedule_word(sched_word_t w);
    sched_result_t r;
    int  pos;
    int  idx;
    bit  done;
    bit  was_frozen;
    r = '{ST_EMPTY, '0, '0, 1'b0, '0, '0};
    if (w.kind == KIND_ADD) begin
      if (rq_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = rq_count;
        if (cur_policy == POL_SJF || cur_policy == POL_AGING)
          for (int k = 0; k < rq_count; k++)
            if (rq_len[k] > w.len) begin
              pos = k;
              break;
            end
        for (int k = rq_count; k > pos; k--) copy_slot(k, k - 1);
        r.pid = pid_ctr;
        pid_ctr++;
        rq_pid[pos] = r.pid; rq_start[pos] = w.start; rq_len[pos] = w.len;
        rq_score[pos] = w.len; rq_pc[pos] = 1;
        rq_count++;
        r.status = ST_ADDED;
      end
    end else if (rq_count != 0) begin
      idx = 0;
      if (cur_policy == POL_RR) begin
        if (rr_pos >= rq_count) rr_pos = 0;
        idx = rr_pos;
      end
      r.status = ST_ISSUED;
      r.pid    = rq_pid[idx];
      r.line   = LINE_W'(rq_start[idx]) + rq_pc[idx] - 1'b1;
      done     = rq_pc[idx] >= rq_len[idx];
      rq_pc[idx]++;
      if (done) begin
        r.fin = 1'b1; r.rel_start = rq_start[idx]; r.rel_len = rq_len[idx];
      end
      case (cur_policy)
        POL_FCFS, POL_SJF: if (done) remove_slot(0);
        POL_RR: begin
          slice_ctr++;
          if (done) begin
            slice_ctr = '0;
            remove_slot(idx);
          end else if (slice_ctr >= cur_quantum) begin
            slice_ctr = '0;
            rr_pos = idx + 1;
            if (rr_pos >= rq_count) rr_pos = 0;
          end
        end
        default: begin
          slice_ctr++;
          if (done || slice_ctr >= cur_slice) begin
            was_frozen = aging_frozen;
            slice_ctr  = '0;
            if (!was_frozen) aging_frozen = age_queue();
            if (done) remove_slot(0);
            if (!was_frozen && rq_count > 0) promote_lowest_score();
          end
        end
      endcase
    end
    return r;
  endfunction

  // Driver: offers the next pending word whenever the slot is free and no random send gap runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(schedule_word(cur_word));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_word  = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_word.kind;
          in_tdata  <= IN_TDATA_W'({cur_word.len, cur_word.start});
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 6);
        end
      end
    end
  end

  // Long receiver hold-off, counted here; triggered once from the sequence.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left      = 0;
      long_hold_done = 0;
    end else if (long_hold_go && !long_hold_done) begin
      hold_left      = 300;
      long_hold_done = 1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Monitor: checks accepted results, then picks next cycle's ready.
  always @(posedge clk) begin
    sched_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word status=%0d data=%h", $time, out_tuser, out_tdata);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_tuser != e.status || out_tdata[7:0] != e.pid ||
              out_tdata[18:8] != e.line || out_tdata[19] != e.fin ||
              out_tdata[29:20] != e.rel_start || out_tdata[39:30] != e.rel_len) begin
            $display("%0t: mismatch expected st=%0d pid=%0d line=%0d fin=%0b rs=%0d rl=%0d",
                     $time, e.status, e.pid, e.line, e.fin, e.rel_start, e.rel_len);
            $display("%0t:          actual   st=%0d pid=%0d line=%0d fin=%0b rs=%0d rl=%0d",
                     $time, out_tuser, out_tdata[7:0], out_tdata[18:8], out_tdata[19],
                     out_tdata[29:20], out_tdata[39:30]);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 6);
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 3000) begin
        $display("%0t: watchdog, no progress", $time);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_POLICY:  cur_policy  = policy_t'(val[1:0]);
      CFG_QUANTUM: cur_quantum = val;
      default:     cur_slice   = val;
    endcase
  endtask

  task automatic set_mode(input policy_t p, input logic [3:0] q, input logic [3:0] s);
    write_reg(CFG_POLICY, {2'b00, p});
    write_reg(CFG_QUANTUM, q);
    write_reg(CFG_SLICE, s);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_word(input logic k, input int st, input int ln);
    pending_words.push_back('{k, ADDR_BITS'(st), ADDR_BITS'(ln)});
  endtask

  // Mostly short programs so they finish; a few long ones reach the high length bits.
  task automatic add_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < step_pct) begin
        add_word(KIND_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        r = $urandom_range(0, 99);
        add_word(KIND_ADD, $urandom_range(0, 1023),
                 r < 60 ? $urandom_range(1, 6) :
                 r < 96 ? $urandom_range(1, 40) : $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    idle_on   = 1;
    step_pct  = 50;
    long_hold_go = 0;
    rq_count = 0; pid_ctr = '0; rr_pos = 0; slice_ctr = '0; aging_frozen = 1'b0;
    cur_policy = POL_FCFS; cur_quantum = 4'd2; cur_slice = 4'd1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty step, zero length, extreme addresses, FCFS after reset.
    add_word(KIND_STEP, 0, 0);
    add_word(KIND_ADD, 1023, 0);
    add_word(KIND_STEP, 0, 0);
    add_word(KIND_ADD, 1023, 3);
    add_word(KIND_ADD, 0, 1);
    repeat (5) add_word(KIND_STEP, 1023, 1023);
    wait_drained();
    // SJF ordering with equal and shorter lengths; fill to full and reject.
    set_mode(POL_SJF, 4'd15, 4'd15);
    add_word(KIND_ADD, 100, 5);
    add_word(KIND_ADD, 200, 2);
    add_word(KIND_ADD, 300, 5);
    for (int i = 0; i < 6; i++) add_word(KIND_ADD, 512 + i, 1 + i);
    repeat (4) add_word(KIND_STEP, 0, 0);
    wait_drained();
    // Aging with the queue kept from SJF; policy change mid-run.
    set_mode(POL_AGING, 4'd0, 4'd0);
    add_random(20);
    wait_drained();

    // Random phases; queue carries over between settings.
    set_mode(POL_RR, 4'd1, 4'd1);
    add_random(250);
    wait_drained();
    set_mode(POL_AGING, 4'd15, 4'd1);
    step_pct = 65;
    add_random(250);
    wait_drained();
    set_mode(POL_RR, 4'd15, 4'd15);
    step_pct = 45;
    long_hold_go = 1;  // receiver stalls while the sender keeps offering
    add_random(250);
    wait_drained();   // sender pause until every result is back
    add_random(100);
    wait_drained();
    set_mode(POL_FCFS, 4'd3, 4'd7);
    step_pct = 55;
    add_random(250);
    wait_drained();
    set_mode(POL_AGING, 4'd2, 4'd4);
    step_pct = 50;
    add_random(250);
    wait_drained();
    set_mode(POL_SJF, 4'd7, 4'd15);
    add_random(200);
    wait_drained();
    set_mode(POL_RR, 4'd2, 4'd2);
    step_pct = 60;
    add_random(200);
    wait_drained();
    // Last stretch at full rate on both sides.
    idle_on = 0;
    set_mode(POL_AGING, 4'd1, 4'd15);
    add_random(250);
    wait_drained();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/rqs_pkg.sv
hdl/ready_queue_scheduler_core.sv
verif/tb_top.sv
